[src/tbbs_pkg.sv]
package tbbs_pkg;

    // Thruster command codes
    typedef enum logic [1:0] {
        CMD_OFF  = 2'd0,
        CMD_STBD = 2'd1,
        CMD_PORT = 2'd2
    } thr_cmd_t;

    // Configuration register indexes
    typedef enum logic [3:0] {
        CFG_ON_THRESHOLD  = 4'd0,
        CFG_OFF_THRESHOLD = 4'd1,
        CFG_LEAD_TIME     = 4'd2,
        CFG_MIN_ON_MS     = 4'd3,
        CFG_MAX_ON_MS     = 4'd4,
        CFG_MIN_OFF_MS    = 4'd5,
        CFG_DUTY_WARN     = 4'd6,
        CFG_DUTY_MAX      = 4'd7
    } cfg_idx_t;

    localparam int CFG_DATA_W = 20;
    localparam int DIV_DVD_W  = 51;
    localparam int DIV_DVS_W  = 34;
    localparam int DIV_CNT_W  = 6;

    localparam logic [32:0] DUTY_WINDOW_MS    = 33'd60000;
    localparam logic [31:0] REVERSAL_DWELL_MS = 32'd2000;
    localparam logic [16:0] DUTY_FULL         = 17'd65536;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = 6'(DIV_DVD_W - 1);

    typedef struct packed {
        logic signed [15:0] heading_error;
        logic signed [15:0] turn_rate;
        logic        [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [16:0] duty_level;
        logic        inhibited;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV_INIT,
        ST_DIV,
        ST_UPDATE,
        ST_WIDEN,
        ST_MUL_SD,
        ST_MUL_ON,
        ST_MUL_OFF,
        ST_DECIDE,
        ST_DONE
    } tbbs_state_t;

    // Datapath commands from the controller
    typedef struct packed {
        logic load_in;
        logic prep;
        logic div_init;
        logic div_step;
        logic update;
        logic widen;
        logic mul_sd;
        logic mul_on;
        logic mul_off;
        logic decide;
        logic load_out;
    } dp_cmd_t;

    // Datapath status to the controller
    typedef struct packed {
        logic dt_zero;
        logic div_last;
    } dp_status_t;

endpackage

[src/tbbs_ctrl.sv]
module tbbs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  tbbs_pkg::dp_status_t status,
    output tbbs_pkg::dp_cmd_t   cmd
);
    import tbbs_pkg::*;

    tbbs_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        slot_free;

    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_PREP;
            ST_PREP:     state_next = status.dt_zero ? ST_WIDEN : ST_DIV_INIT;
            ST_DIV_INIT: state_next = ST_DIV;
            ST_DIV:      if (status.div_last) state_next = ST_UPDATE;
            ST_UPDATE:   state_next = ST_WIDEN;
            ST_WIDEN:    state_next = ST_MUL_SD;
            ST_MUL_SD:   state_next = ST_MUL_ON;
            ST_MUL_ON:   state_next = ST_MUL_OFF;
            ST_MUL_OFF:  state_next = ST_DECIDE;
            ST_DECIDE:   state_next = ST_DONE;
            ST_DONE:     if (slot_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd          = '0;
        cmd.load_in  = (state_reg == ST_IDLE) && in_valid;
        cmd.prep     = (state_reg == ST_PREP);
        cmd.div_init = (state_reg == ST_DIV_INIT);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.update   = (state_reg == ST_UPDATE);
        cmd.widen    = (state_reg == ST_WIDEN);
        cmd.mul_sd   = (state_reg == ST_MUL_SD);
        cmd.mul_on   = (state_reg == ST_MUL_ON);
        cmd.mul_off  = (state_reg == ST_MUL_OFF);
        cmd.decide   = (state_reg == ST_DECIDE);
        cmd.load_out = (state_reg == ST_DONE) && slot_free;
    end

    // Output beat valid: set on load, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_accept_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_PREP))
        else $error("accepted beat did not start processing");

    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && status.div_last) |=> (state_reg == ST_UPDATE))
        else $error("divider did not hand over to update");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || !out_stall))
        else $error("output beat overwritten while stalled");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && state_next == ST_IDLE) |=> out_valid_reg)
        else $error("finished item left no output beat");
`endif

endmodule

[src/tbbs_datapath.sv]
module tbbs_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [3:0]          cfg_index,
    input  logic [tbbs_pkg::CFG_DATA_W-1:0] cfg_data,
    input  tbbs_pkg::in_item_t  in_data,
    input  tbbs_pkg::dp_cmd_t   cmd,
    output tbbs_pkg::dp_status_t status,
    output tbbs_pkg::out_item_t out_data
);
    import tbbs_pkg::*;

    // Configuration registers
    logic [14:0] on_thr_reg, off_thr_reg;
    logic [11:0] lead_reg;
    logic [15:0] min_on_reg, min_off_reg;
    logic [19:0] max_on_reg;
    logic [16:0] warn_reg, dmax_reg;

    // Persistent state
    thr_cmd_t    cmd_reg, cmd_next;
    thr_cmd_t    last_dir_reg, last_dir_next;
    logic [31:0] entered_reg, entered_next;
    logic [31:0] last_tick_reg;
    logic [16:0] avg_reg, avg_next;
    logic        inhibit_reg, inhibit_next;

    // Per-item working registers
    logic signed [15:0] err_reg, rate_reg;
    logic [31:0] now_reg, dt_reg;
    logic [16:0] mag_reg;
    logic        rise_reg;
    logic [48:0] num_reg;
    logic signed [28:0] s_reg;
    logic [DIV_DVD_W-1:0] dvd_reg;
    logic [DIV_DVS_W-1:0] dvs_reg;
    logic [DIV_DVS_W:0]   rem_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [16:0] d_reg;
    logic [17:0] dn_reg;
    logic signed [46:0] sd_reg;
    logic [40:0] on_eff_reg, off_eff_reg;
    out_item_t   out_reg;

    // Combinational helpers
    logic [32:0]          den;
    logic [DIV_DVS_W:0]   rem_sh;
    logic                 q_bit;
    logic [17:0]          q_raw;
    logic [16:0]          q_clamp;
    logic [16:0]          d_calc, n_calc, n_raw;
    logic signed [46:0]   on_s, off_s;
    logic [31:0]          elapsed, required;
    thr_cmd_t             requested;
    logic                 allowed;

    assign status.dt_zero  = (dt_reg == 32'd0);
    assign status.div_last = (cnt_reg == '0);
    assign out_data        = out_reg;

    // Divider step and rounding inputs
    assign den    = DUTY_WINDOW_MS + {1'b0, dt_reg};
    assign rem_sh = {rem_reg[DIV_DVS_W-1:0], dvd_reg[DIV_DVD_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, dvs_reg});
    assign q_raw  = dvd_reg[17:0];
    assign q_clamp = (q_raw > {1'b0, mag_reg}) ? mag_reg : q_raw[16:0];

    // Duty average step and inhibit hysteresis
    always_comb
    begin
        avg_next     = rise_reg ? (avg_reg + q_clamp) : (avg_reg - q_clamp);
        inhibit_next = inhibit_reg;
        if (avg_next >= dmax_reg)
            inhibit_next = 1'b1;
        else if (avg_next < warn_reg)
            inhibit_next = 1'b0;
    end

    // Deadband widening span
    always_comb
    begin
        n_raw = avg_reg - warn_reg;
        if (dmax_reg > warn_reg)
        begin
            d_calc = dmax_reg - warn_reg;
            if (avg_reg <= warn_reg)
                n_calc = 17'd0;
            else if (n_raw > d_calc)
                n_calc = d_calc;
            else
                n_calc = n_raw;
        end
        else
        begin
            d_calc = 17'd1;
            n_calc = 17'd0;
        end
    end

    // Switching decision
    assign on_s    = $signed({6'd0, on_eff_reg});
    assign off_s   = $signed({6'd0, off_eff_reg});
    assign elapsed = now_reg - entered_reg;

    always_comb
    begin
        requested = cmd_reg;
        if (cmd_reg == CMD_OFF)
        begin
            if (!inhibit_reg)
            begin
                if (sd_reg > on_s)
                    requested = CMD_STBD;
                else if (sd_reg < -on_s)
                    requested = CMD_PORT;
            end
        end
        else if (elapsed >= {12'd0, max_on_reg})
            requested = CMD_OFF;
        else if ((cmd_reg == CMD_STBD && sd_reg < off_s) ||
                 (cmd_reg == CMD_PORT && sd_reg > -off_s))
            requested = CMD_OFF;

        required = {16'd0, min_off_reg};
        if (cmd_reg == CMD_OFF)
        begin
            if (last_dir_reg != CMD_OFF && requested != last_dir_reg &&
                REVERSAL_DWELL_MS > required)
                required = REVERSAL_DWELL_MS;
        end
        else
            required = {16'd0, min_on_reg};
        allowed = (elapsed >= required);

        cmd_next      = cmd_reg;
        last_dir_next = last_dir_reg;
        entered_next  = entered_reg;
        if (requested != cmd_reg && allowed)
        begin
            if (cmd_reg != CMD_OFF)
                last_dir_next = cmd_reg;
            cmd_next     = requested;
            entered_next = now_reg;
        end
    end

    // Configuration and persistent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_thr_reg    <= 15'd640;
            off_thr_reg   <= 15'd256;
            lead_reg      <= 12'd256;
            min_on_reg    <= 16'd500;
            max_on_reg    <= 20'd10000;
            min_off_reg   <= 16'd500;
            warn_reg      <= 17'd32768;
            dmax_reg      <= 17'd52429;
            cmd_reg       <= CMD_OFF;
            last_dir_reg  <= CMD_OFF;
            entered_reg   <= 32'd0;
            last_tick_reg <= 32'd0;
            avg_reg       <= 17'd0;
            inhibit_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_ON_THRESHOLD:  on_thr_reg  <= cfg_data[14:0];
                    CFG_OFF_THRESHOLD: off_thr_reg <= cfg_data[14:0];
                    CFG_LEAD_TIME:     lead_reg    <= cfg_data[11:0];
                    CFG_MIN_ON_MS:     min_on_reg  <= cfg_data[15:0];
                    CFG_MAX_ON_MS:     max_on_reg  <= cfg_data[19:0];
                    CFG_MIN_OFF_MS:    min_off_reg <= cfg_data[15:0];
                    CFG_DUTY_WARN:     warn_reg    <= cfg_data[16:0];
                    CFG_DUTY_MAX:      dmax_reg    <= cfg_data[16:0];
                    default:           ;
                endcase
            end
            if (cmd.load_in)
                last_tick_reg <= in_data.now_ms;
            if (cmd.update)
            begin
                avg_reg     <= avg_next;
                inhibit_reg <= inhibit_next;
            end
            if (cmd.decide)
            begin
                cmd_reg      <= cmd_next;
                last_dir_reg <= last_dir_next;
                entered_reg  <= entered_next;
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            err_reg  <= in_data.heading_error;
            rate_reg <= in_data.turn_rate;
            now_reg  <= in_data.now_ms;
            dt_reg   <= in_data.now_ms - last_tick_reg;
            rise_reg <= (cmd_reg != CMD_OFF);
            mag_reg  <= (cmd_reg != CMD_OFF) ? (DUTY_FULL - avg_reg) : avg_reg;
        end
        if (cmd.prep)
        begin
            num_reg <= 49'(mag_reg) * 49'(dt_reg);
            s_reg   <= 29'({{5{err_reg[15]}}, err_reg, 8'd0})
                     - 29'($signed({1'b0, lead_reg}) * rate_reg);
        end
        if (cmd.div_init)
        begin
            dvd_reg <= {num_reg, 1'b0} + DIV_DVD_W'(den);
            dvs_reg <= {den, 1'b0};
            rem_reg <= '0;
            cnt_reg <= DIV_LAST_STEP;
        end
        if (cmd.div_step)
        begin
            rem_reg <= q_bit ? (rem_sh - {1'b0, dvs_reg}) : rem_sh;
            dvd_reg <= {dvd_reg[DIV_DVD_W-2:0], q_bit};
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (cmd.widen)
        begin
            d_reg  <= d_calc;
            dn_reg <= {1'b0, d_calc} + {1'b0, n_calc};
        end
        if (cmd.mul_sd)
            sd_reg <= 47'(s_reg) * $signed({30'd0, d_reg});
        if (cmd.mul_on)
            on_eff_reg <= {33'(on_thr_reg) * 33'(dn_reg), 8'd0};
        if (cmd.mul_off)
            off_eff_reg <= {33'(off_thr_reg) * 33'(dn_reg), 8'd0};
        if (cmd.load_out)
        begin
            out_reg.command    <= cmd_reg;
            out_reg.duty_level <= avg_reg;
            out_reg.inhibited  <= inhibit_reg;
        end
    end

`ifndef SYNTHESIS
    a_avg_range: assert property (@(posedge clk) disable iff (!rst_n)
        avg_reg <= DUTY_FULL)
        else $error("duty average left its range");

    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(cmd.decide) |-> $stable(cmd_reg))
        else $error("command changed outside decision step");

    a_inhibit_set: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && avg_next >= dmax_reg) |=> inhibit_reg)
        else $error("inhibit not set at duty max");
`endif

endmodule

[src/thruster_bang_bang_switcher.sv]
// Channel  | Handshake           | Payload
// ---------+---------------------+--------------------------------------------
// in       | in_valid / in_stall | in_data: heading_error, turn_rate, now_ms
// out      | out_valid/out_stall | out_data: command, duty_level, inhibited
// cfg      | cfg_we              | cfg_index, cfg_data
//
// One item at a time; when time advanced, each tick runs the 51-step
// restoring divider for the duty average, which is skipped when the
// timestamp repeats.
// Reset (rst_n low, async) restores default registers, command off, zero duty.
// A result waits in an output register; the next beat is taken meanwhile,
// and only the final load holds while out_stall is high.
module thruster_bang_bang_switcher (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  tbbs_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output tbbs_pkg::out_item_t out_data,
    input  logic                cfg_we,
    input  logic [3:0]          cfg_index,
    input  logic [tbbs_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tbbs_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    tbbs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    tbbs_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

endmodule
